// ===== rtl/cwtg_pkg.sv =====
// Shared constants, types and helpers for the caption window text grid.
`default_nettype none
package cwtg_pkg;
	localparam int MAX_ROWS = 16;
	localparam int MAX_COLUMNS = 64;
	localparam int ATTR_BITS = 40;
	localparam int CELLS = MAX_ROWS * MAX_COLUMNS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int CHAR_W = 16;
	localparam int CELL_W = CHAR_W + ATTR_BITS;
	localparam int ATTR_W = 40;
	localparam int ROW_W = 4;
	localparam int COL_W = 6;
	localparam int PEN_ROW_W = 5;
	localparam int PEN_COL_W = 6;
	localparam int RIX_W = $clog2(MAX_ROWS);
	localparam int CIX_W = $clog2(MAX_COLUMNS);
	localparam int CFG_ROWS_W = 5;
	localparam int CFG_COLS_W = 7;
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	localparam logic [CHAR_W-1:0] CH_CR = 16'h000D;
	localparam logic [CHAR_W-1:0] CH_BS = 16'h0008;
	localparam logic [CHAR_W-1:0] CH_SPACE = 16'h0020;

	localparam logic [1:0] DIR_LR = 2'd0;
	localparam logic [1:0] DIR_RL = 2'd1;
	localparam logic [1:0] DIR_TB = 2'd2;
	localparam logic [1:0] DIR_BT = 2'd3;

	typedef enum logic [1:0] {
		OP_PUT   = 2'd0,
		OP_PEN   = 2'd1,
		OP_CLEAR = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		REG_ENABLE    = 3'd0,
		REG_ROWS      = 3'd1,
		REG_COLS      = 3'd2,
		REG_PRINT_DIR = 3'd3,
		REG_SCROLL_DIR = 3'd4,
		REG_LOCK_ROWS = 3'd5,
		REG_LOCK_COLS = 3'd6
	} reg_t;

	typedef enum logic [2:0] {
		K_PUT,
		K_CR,
		K_BS,
		K_PEN,
		K_CLEAR,
		K_READ
	} kind_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_SCROLL,
		ST_DRAIN,
		ST_BLANK,
		ST_CLEAR,
		ST_FIN
	} state_t;

	typedef struct packed {
		kind_t                kind;
		logic [CHAR_W-1:0]    ch;
		logic [ATTR_BITS-1:0] attr;
		logic [ROW_W-1:0]     trow;
		logic [COL_W-1:0]     tcol;
	} cmd_t;

	typedef struct packed {
		logic                  enabled;
		logic [CFG_ROWS_W-1:0] rows;
		logic [CFG_COLS_W-1:0] cols;
		logic [1:0]            pdir;
		logic [1:0]            sdir;
		logic                  lock_rows;
		logic                  lock_cols;
	} cfg_t;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [RIX_W-1:0] row,
			input logic [CIX_W-1:0] col);
		cell_addr = ADDR_W'(int'(row) * MAX_COLUMNS + int'(col));
	endfunction
endpackage
`default_nettype wire

// ===== rtl/caption_window_text_grid.sv =====
// Top level of the caption window text grid: configuration registers, front and back parts.
//
// Input channel in_valid/in_stall carries one command beat: opcode, char_code,
// pen_attribute, target_row, target_column. Output channel out_valid/out_stall
// returns one result beat per command, in order.
// A two-entry command queue sits in front of the executor, so commands are
// taken while a result waits under out_stall; a full queue raises in_stall.
// Put character, set pen and read: the command is popped in IDLE, finishes in FIN and its
// result beat is registered; the next command is popped only after FIN returns to IDLE.
// A clear writes every cell, one per cycle, in the CLEAR state before FIN.
// A scroll copies (rows-1)*cols cells and blanks cols cells through the
// single-write-port cell memory, in the SCROLL, DRAIN and BLANK states.
// After reset the cell memory is swept to spaces with zero attribute, with
// in_stall high; the APB port stays writable meanwhile.
// Configuration is written over APB at byte address 4*index, with pready always
// high; write only while no command is in flight.
`default_nettype none
module caption_window_text_grid import cwtg_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [PADDR_W-1:0]    paddr,
	input  wire logic [PDATA_W-1:0]    pwdata,
	output logic      [PDATA_W-1:0]    prdata,
	output logic                       pready,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [1:0]            opcode,
	input  wire logic [CHAR_W-1:0]     char_code,
	input  wire logic [ATTR_W-1:0]     pen_attribute,
	input  wire logic [ROW_W-1:0]      target_row,
	input  wire logic [COL_W-1:0]      target_column,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [CHAR_W-1:0]          read_char,
	output logic [ATTR_W-1:0]          read_attribute,
	output logic [PEN_ROW_W-1:0]       pen_row_now,
	output logic [PEN_COL_W-1:0]       pen_column_now,
	output logic                       content_changed
);
	cfg_t  cfg_q;
	logic  wr_en, init_busy, q_valid, q_pop;
	cmd_t  q_cmd;
	reg_t  ridx;

	assign pready = 1'b1;
	assign ridx = reg_t'(paddr[4:2]);
	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled <= 1'b0;
			cfg_q.rows <= CFG_ROWS_W'(1);
			cfg_q.cols <= CFG_COLS_W'(1);
			cfg_q.pdir <= DIR_LR;
			cfg_q.sdir <= DIR_BT;
			cfg_q.lock_rows <= 1'b0;
			cfg_q.lock_cols <= 1'b0;
		end else if (wr_en) begin
			case (ridx)
				REG_ENABLE: cfg_q.enabled <= pwdata[0];
				REG_ROWS: cfg_q.rows <= pwdata[CFG_ROWS_W-1:0];
				REG_COLS: cfg_q.cols <= pwdata[CFG_COLS_W-1:0];
				REG_PRINT_DIR: cfg_q.pdir <= pwdata[1:0];
				REG_SCROLL_DIR: cfg_q.sdir <= pwdata[1:0];
				REG_LOCK_ROWS: cfg_q.lock_rows <= pwdata[0];
				REG_LOCK_COLS: cfg_q.lock_cols <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			REG_ENABLE: prdata = PDATA_W'(cfg_q.enabled);
			REG_ROWS: prdata = PDATA_W'(cfg_q.rows);
			REG_COLS: prdata = PDATA_W'(cfg_q.cols);
			REG_PRINT_DIR: prdata = PDATA_W'(cfg_q.pdir);
			REG_SCROLL_DIR: prdata = PDATA_W'(cfg_q.sdir);
			REG_LOCK_ROWS: prdata = PDATA_W'(cfg_q.lock_rows);
			REG_LOCK_COLS: prdata = PDATA_W'(cfg_q.lock_cols);
			default: prdata = '0;
		endcase
	end

	cwtg_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .char_code(char_code), .pen_attribute(pen_attribute),
		.target_row(target_row), .target_column(target_column),
		.hold(init_busy), .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
	);

	cwtg_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop), .init_busy(init_busy),
		.out_valid(out_valid), .out_stall(out_stall),
		.read_char(read_char), .read_attribute(read_attribute),
		.pen_row_now(pen_row_now), .pen_column_now(pen_column_now),
		.content_changed(content_changed)
	);

	a_init_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		init_busy |-> in_stall)
		else $error("input taken during memory sweep");

	a_edit_not_read: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && content_changed |-> read_char == '0)
		else $error("edit result carries read data");

	a_pen_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pen_row_now <= PEN_ROW_W'(MAX_ROWS))
		else $error("pen row out of range");

	a_pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid && !init_busy)
		else $error("pop from empty queue");
endmodule
`default_nettype wire

// ===== rtl/cwtg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cwtg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== rtl/cwtg_front.sv =====
// Input acceptance, opcode classification and two-entry command queue.
`default_nettype none
module cwtg_front import cwtg_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [1:0]           opcode,
	input  wire logic [CHAR_W-1:0]    char_code,
	input  wire logic [ATTR_W-1:0]    pen_attribute,
	input  wire logic [ROW_W-1:0]     target_row,
	input  wire logic [COL_W-1:0]     target_column,
	input  wire logic                 hold,
	output logic                      q_valid,
	output cmd_t                      q_cmd,
	input  wire logic                 q_pop
);
	cmd_t       ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	cmd_t       cmd;
	logic       acc;

	always_comb begin
		cmd.ch = char_code;
		cmd.attr = ATTR_BITS'(pen_attribute);
		cmd.trow = target_row;
		cmd.tcol = target_column;
		case (op_t'(opcode))
			OP_PUT: begin
				if (char_code == CH_CR) begin
					cmd.kind = K_CR;
				end else if (char_code == CH_BS) begin
					cmd.kind = K_BS;
				end else begin
					cmd.kind = K_PUT;
				end
			end
			OP_PEN: cmd.kind = K_PEN;
			OP_CLEAR: cmd.kind = K_CLEAR;
			default: cmd.kind = K_READ;
		endcase
	end

	assign in_stall = (cnt_q == 2'd2) || hold;
	assign acc = in_valid && !in_stall;
	assign q_valid = (cnt_q != 2'd0);
	assign q_cmd = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (acc) begin
			ent_q[wp_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (acc) begin
				wp_q <= !wp_q;
			end
			if (q_pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, acc} - {1'b0, q_pop};
		end
	end
endmodule
`default_nettype wire

// ===== rtl/cwtg_back.sv =====
// Command execution: pen update, cell writes, scroll and clear sweeps, result register.
`default_nettype none
module cwtg_back import cwtg_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cfg_t                  cfg,
	input  wire logic                  q_valid,
	input  wire cmd_t                  q_cmd,
	output logic                       q_pop,
	output logic                       init_busy,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [CHAR_W-1:0]          read_char,
	output logic [ATTR_W-1:0]          read_attribute,
	output logic [PEN_ROW_W-1:0]       pen_row_now,
	output logic [PEN_COL_W-1:0]       pen_column_now,
	output logic                       content_changed
);
	state_t state_q, state_d;

	logic [PEN_ROW_W-1:0] pr_q;
	logic [PEN_COL_W-1:0] pc_q;
	kind_t                kind_q;
	logic [ATTR_BITS-1:0] attr_q;
	logic                 rd_ok_q, chg_q;
	logic [RIX_W-1:0]     sr_q;
	logic [CIX_W-1:0]     sc_q;
	logic [ADDR_W-1:0]    ci_q;
	logic                 pend_s1;
	logic [ADDR_W-1:0]    pend_addr_s1;

	logic                 ov_q, ochg_q;
	logic [CHAR_W-1:0]    oc_q;
	logic [ATTR_W-1:0]    oa_q;
	logic [PEN_ROW_W-1:0] opr_q;
	logic [PEN_COL_W-1:0] opc_q;

	logic signed [8:0] rs, cs, prs, pcs, nr, nc, d;
	logic              scr, pen_ok, act, wrap, slot_free, rd_ok;
	logic              we, re;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [CELL_W-1:0] wdata, rdata;
	logic [RIX_W-1:0]  last_row;
	logic [CIX_W-1:0]  last_col;

	cwtg_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.re(re), .raddr(raddr), .rdata(rdata)
	);

	// window size and pen step
	always_comb begin
		if (cfg.rows == '0) begin
			rs = 9'sd1;
		end else if (int'(cfg.rows) > MAX_ROWS) begin
			rs = 9'(MAX_ROWS);
		end else begin
			rs = $signed(9'(cfg.rows));
		end
		if (cfg.cols == '0) begin
			cs = 9'sd1;
		end else if (int'(cfg.cols) > MAX_COLUMNS) begin
			cs = 9'(MAX_COLUMNS);
		end else begin
			cs = $signed(9'(cfg.cols));
		end
		prs = $signed(9'(pr_q));
		pcs = $signed(9'(pc_q));
		last_row = RIX_W'(rs - 9'sd1);
		last_col = CIX_W'(cs - 9'sd1);
		pen_ok = (prs < rs) && (pcs < cs);
		wrap = !cfg.lock_rows && cfg.lock_cols;
		d = (q_cmd.kind == K_BS) ? -9'sd1 : 9'sd1;
		nr = prs;
		nc = pcs;
		scr = 1'b0;
		case (q_cmd.kind)
			K_PUT, K_BS: begin
				case (cfg.pdir)
					DIR_LR: nc = nc + d;
					DIR_RL: nc = nc - d;
					DIR_TB: nr = nr + d;
					default: nr = nr - d;
				endcase
				if (!cfg.pdir[1]) begin
					if (wrap && nc >= cs) begin
						nc = 9'sd0;
						nr = nr + 9'sd1;
					end else if (wrap && nc < 9'sd0) begin
						nc = cs - 9'sd1;
						nr = nr - 9'sd1;
					end
					if (cfg.sdir == DIR_BT && nr >= rs) begin
						scr = 1'b1;
						nr = rs - 9'sd1;
					end
				end
				if (nr < 9'sd0) nr = 9'sd0;
				if (nc < 9'sd0) nc = 9'sd0;
				if (nr > rs - 9'sd1) nr = rs - 9'sd1;
				if (nc > cs - 9'sd1) nc = cs - 9'sd1;
			end
			K_CR: begin
				nr = prs + 9'sd1;
				nc = 9'sd0;
				if (cfg.sdir == DIR_BT && nr >= rs) begin
					scr = 1'b1;
					nr = rs - 9'sd1;
				end
			end
			K_PEN: begin
				nr = $signed(9'(q_cmd.trow));
				nc = $signed(9'(q_cmd.tcol));
				if (cfg.sdir == DIR_BT && nr >= rs) begin
					scr = 1'b1;
					nr = rs - 9'sd1;
				end
				if (nr > rs - 9'sd1) nr = rs - 9'sd1;
				if (nc > cs - 9'sd1) nc = cs - 9'sd1;
			end
			default: ;
		endcase
		case (q_cmd.kind)
			K_PUT, K_CR, K_BS: act = cfg.enabled && pen_ok;
			K_PEN, K_CLEAR: act = cfg.enabled;
			default: act = 1'b0;
		endcase
		rd_ok = (int'(q_cmd.trow) < MAX_ROWS) && (int'(q_cmd.tcol) < MAX_COLUMNS);
	end

	assign slot_free = !ov_q || !out_stall;

	// sequencer
	always_comb begin
		state_d = state_q;
		q_pop = 1'b0;
		we = 1'b0;
		waddr = '0;
		wdata = {attr_q, CH_SPACE};
		re = 1'b0;
		raddr = '0;
		case (state_q)
			ST_INIT: begin
				we = 1'b1;
				waddr = ci_q;
				if (ci_q == ADDR_W'(CELLS - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					state_d = ST_FIN;
					if (q_cmd.kind == K_READ) begin
						re = 1'b1;
						raddr = cell_addr(RIX_W'(q_cmd.trow), CIX_W'(q_cmd.tcol));
					end else if (act) begin
						if (q_cmd.kind == K_PUT) begin
							we = 1'b1;
							waddr = cell_addr(RIX_W'(pr_q), CIX_W'(pc_q));
							wdata = {q_cmd.attr, q_cmd.ch};
						end else if (q_cmd.kind == K_BS && !scr) begin
							we = 1'b1;
							waddr = cell_addr(RIX_W'(nr), CIX_W'(nc));
							wdata = {q_cmd.attr, CH_SPACE};
						end
						if (q_cmd.kind == K_CLEAR) begin
							state_d = ST_CLEAR;
						end else if (scr) begin
							state_d = (rs == 9'sd1) ? ST_BLANK : ST_SCROLL;
						end
					end
				end
			end
			ST_SCROLL: begin
				re = 1'b1;
				raddr = cell_addr(sr_q + RIX_W'(1), sc_q);
				we = pend_s1;
				waddr = pend_addr_s1;
				wdata = rdata;
				if (sc_q == last_col && sr_q == RIX_W'(rs - 9'sd2)) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				we = pend_s1;
				waddr = pend_addr_s1;
				wdata = rdata;
				state_d = ST_BLANK;
			end
			ST_BLANK: begin
				we = 1'b1;
				waddr = cell_addr(last_row, sc_q);
				if (sc_q == last_col) state_d = ST_FIN;
			end
			ST_CLEAR: begin
				we = 1'b1;
				waddr = ci_q;
				if (ci_q == ADDR_W'(CELLS - 1)) state_d = ST_FIN;
			end
			ST_FIN: begin
				if (slot_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pr_q <= '0;
			pc_q <= '0;
			kind_q <= K_PUT;
			attr_q <= '0;
			rd_ok_q <= 1'b0;
			chg_q <= 1'b0;
			sr_q <= '0;
			sc_q <= '0;
			ci_q <= '0;
			pend_s1 <= 1'b0;
			pend_addr_s1 <= '0;
			ov_q <= 1'b0;
		end else begin
			case (state_q)
				ST_INIT, ST_CLEAR: ci_q <= ci_q + ADDR_W'(1);
				ST_IDLE: begin
					if (q_valid) begin
						kind_q <= q_cmd.kind;
						attr_q <= q_cmd.attr;
						rd_ok_q <= rd_ok;
						sr_q <= '0;
						sc_q <= '0;
						ci_q <= '0;
						pend_s1 <= 1'b0;
						chg_q <= act && (q_cmd.kind != K_PEN || scr);
						if (act && q_cmd.kind != K_CLEAR) begin
							pr_q <= PEN_ROW_W'(nr);
							pc_q <= PEN_COL_W'(nc);
						end
					end
				end
				ST_SCROLL: begin
					pend_s1 <= 1'b1;
					pend_addr_s1 <= cell_addr(sr_q, sc_q);
					if (sc_q == last_col) begin
						sc_q <= '0;
						sr_q <= sr_q + RIX_W'(1);
					end else begin
						sc_q <= sc_q + CIX_W'(1);
					end
				end
				ST_DRAIN: begin
					pend_s1 <= 1'b0;
					sc_q <= '0;
				end
				ST_BLANK: sc_q <= sc_q + CIX_W'(1);
				default: ;
			endcase
			if (state_q == ST_FIN && slot_free) begin
				ov_q <= 1'b1;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && slot_free) begin
			if (kind_q == K_READ && rd_ok_q) begin
				oc_q <= rdata[CHAR_W-1:0];
				oa_q <= ATTR_W'(rdata[CELL_W-1:CHAR_W]);
			end else begin
				oc_q <= '0;
				oa_q <= '0;
			end
			opr_q <= pr_q;
			opc_q <= pc_q;
			ochg_q <= chg_q;
		end
	end

	assign init_busy = (state_q == ST_INIT);
	assign out_valid = ov_q;
	assign read_char = oc_q;
	assign read_attribute = oa_q;
	assign pen_row_now = opr_q;
	assign pen_column_now = opc_q;
	assign content_changed = ochg_q;
endmodule
`default_nettype wire
